/* rtl/core/bcfm_pkg.sv */
package bcfm_pkg;

	// Data byte and identifier types
	typedef logic [7:0]  byte_t;
	typedef logic [28:0] can_id_t;
	typedef logic [2:0]  byte_pos_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_MIN_HIGH_INDEX = 3'd0,
		CFG_MIN_LOW_INDEX  = 3'd1,
		CFG_MAX_HIGH_INDEX = 3'd2,
		CFG_MAX_LOW_INDEX  = 3'd3,
		CFG_PUMP_STATUS_ID = 3'd4
	} cfg_reg_t;

	// Configuration reset values
	localparam byte_pos_t MIN_HIGH_RST = 3'd2;
	localparam byte_pos_t MIN_LOW_RST  = 3'd3;
	localparam byte_pos_t MAX_HIGH_RST = 3'd4;
	localparam byte_pos_t MAX_LOW_RST  = 3'd5;
	localparam can_id_t   PUMP_ID_RST  = 29'h18FF0300;

	// Identifier fields
	localparam logic [20:0] SUMMARY_PREFIX = 21'h18FF0E; // id[28:8] of a summary frame
	localparam logic [3:0]  FAMILY_NIBBLE  = 4'hE;       // id[11:8] of the summary family
	localparam logic [12:0] TYPE_PREFIX    = 13'h18FF;   // id[28:16] of typed module frames

	// Fixed result widths
	localparam int COV_W   = 36;
	localparam int STALE_W = 3;

endpackage

/* rtl/core/battery_cell_frame_monitor_top.sv */
// Battery cell frame monitor.
// Input channel: one received CAN frame per request (frame_id, byte0..byte7, now_ms),
// taken when in_valid is high and in_stall is low.
// Output channel: one result per frame (pack lowest/highest cell, coverage masks,
// stale-counter clear mask, ghost flag, updated module, pump decode), taken when
// out_valid is high and out_stall is low.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write it only while no frame is in flight.
// The request passes through one input register, then the state and result registers.
// A new frame can be taken every cycle while the receiver does not stall; the single
// compare-and-select pass from the input register to the state registers sets that.
// When the receiver stalls, the result holds, the input register fills and in_stall
// rises once it holds a frame. Reset clears all stored module values, masks, flags,
// pump decode and pack values to zero and loads the configuration reset values.
module battery_cell_frame_monitor_top import bcfm_pkg::*; #(
	parameter int MODULES     = 3,
	parameter int CELL_STRIDE = 32,
	parameter int FRAME_TYPES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [28:0] cfg_data,
	// Frame input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [28:0] frame_id,
	input  logic [7:0]  byte0,
	input  logic [7:0]  byte1,
	input  logic [7:0]  byte2,
	input  logic [7:0]  byte3,
	input  logic [7:0]  byte4,
	input  logic [7:0]  byte5,
	input  logic [7:0]  byte6,
	input  logic [7:0]  byte7,
	input  logic [31:0] now_ms,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] lowest_volt,
	output logic [8:0]  lowest_cell,
	output logic [15:0] highest_volt,
	output logic [8:0]  highest_cell,
	output logic [35:0] coverage_bits,
	output logic [2:0]  stale_clear,
	output logic        ghost_flag,
	output logic [1:0]  updated_module,
	output logic [3:0]  pump_state,
	output logic [15:0] pump_speed,
	output logic [3:0]  pump_fault_bits
);

	localparam int SEEN_W = MODULES * FRAME_TYPES;

	// Configuration registers
	byte_pos_t min_high_q, min_low_q, max_high_q, max_low_q;
	can_id_t   pump_id_q;

	// Input register
	logic      valid_s1;
	can_id_t   id_s1;
	byte_t     data_s1 [8];

	// Module and pack state
	logic [15:0] min_volt_q [MODULES];
	byte_t       min_cell_q [MODULES];
	logic [15:0] max_volt_q [MODULES];
	byte_t       max_cell_q [MODULES];
	logic [SEEN_W-1:0] seen_q;
	logic        ghost_q;
	logic [3:0]  pump_state_q;
	logic [15:0] pump_speed_q;
	logic [3:0]  pump_faults_q;
	logic [15:0] low_volt_q, high_volt_q;
	logic [8:0]  low_cell_q, high_cell_q;
	logic [MODULES-1:0] stale_q;
	logic [1:0]  updated_q;
	logic        out_valid_q;

	// Next values
	logic [15:0] min_volt_d [MODULES];
	byte_t       min_cell_d [MODULES];
	logic [15:0] max_volt_d [MODULES];
	byte_t       max_cell_d [MODULES];
	logic [SEEN_W-1:0] seen_d;
	logic        ghost_d;
	logic [15:0] low_volt_d, high_volt_d;
	logic [8:0]  low_cell_d, high_cell_d;
	logic [MODULES-1:0] stale_d;
	logic [1:0]  updated_d;
	logic [15:0] new_min, new_max;
	logic [15:0] scan_lo, scan_hi;
	logic [8:0]  scan_lo_cell, scan_hi_cell;
	logic [7:0]  frame_type, frame_mod;
	logic        summary_hit, family_hit, type_ok;
	logic        advance;

	// Widened views for fixed-width result ports
	logic [SEEN_W+COV_W-1:0]     cov_ext;
	logic [MODULES+STALE_W-1:0]  stale_ext;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_high_q <= MIN_HIGH_RST;
			min_low_q  <= MIN_LOW_RST;
			max_high_q <= MAX_HIGH_RST;
			max_low_q  <= MAX_LOW_RST;
			pump_id_q  <= PUMP_ID_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_MIN_HIGH_INDEX: min_high_q <= cfg_data[2:0];
				CFG_MIN_LOW_INDEX:  min_low_q  <= cfg_data[2:0];
				CFG_MAX_HIGH_INDEX: max_high_q <= cfg_data[2:0];
				CFG_MAX_LOW_INDEX:  max_low_q  <= cfg_data[2:0];
				CFG_PUMP_STATUS_ID: pump_id_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the request into the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			id_s1      <= frame_id;
			data_s1[0] <= byte0;
			data_s1[1] <= byte1;
			data_s1[2] <= byte2;
			data_s1[3] <= byte3;
			data_s1[4] <= byte4;
			data_s1[5] <= byte5;
			data_s1[6] <= byte6;
			data_s1[7] <= byte7;
		end
	end

	// Decode the frame and work out the next state
	always_comb begin
		frame_type  = id_s1[15:8];
		frame_mod   = id_s1[7:0];
		summary_hit = (id_s1[28:8] == SUMMARY_PREFIX);
		family_hit  = (id_s1[11:8] == FAMILY_NIBBLE);
		type_ok     = (id_s1[28:16] == TYPE_PREFIX) && (frame_type != 8'd0)
		              && (frame_type <= 8'(FRAME_TYPES));
		new_min     = {data_s1[min_high_q], data_s1[min_low_q]};
		new_max     = {data_s1[max_high_q], data_s1[max_low_q]};

		// Store the summary of the addressed module
		updated_d = 2'd0;
		for (int m = 0; m < MODULES; m++) begin
			min_volt_d[m] = min_volt_q[m];
			min_cell_d[m] = min_cell_q[m];
			max_volt_d[m] = max_volt_q[m];
			max_cell_d[m] = max_cell_q[m];
			if (summary_hit && frame_mod == 8'(m + 1)) begin
				min_volt_d[m] = new_min;
				min_cell_d[m] = data_s1[0];
				max_volt_d[m] = new_max;
				max_cell_d[m] = data_s1[1];
				updated_d     = 2'(m + 1);
			end
		end

		// Scan the modules for pack extremes; on a tie the later module wins
		scan_lo      = min_volt_d[0];
		scan_lo_cell = {1'b0, min_cell_d[0]};
		scan_hi      = max_volt_d[0];
		scan_hi_cell = {1'b0, max_cell_d[0]};
		for (int m = 1; m < MODULES; m++) begin
			if (min_volt_d[m] <= scan_lo) begin
				scan_lo      = min_volt_d[m];
				scan_lo_cell = {1'b0, min_cell_d[m]} + 9'(m * CELL_STRIDE);
			end
			if (max_volt_d[m] >= scan_hi) begin
				scan_hi      = max_volt_d[m];
				scan_hi_cell = {1'b0, max_cell_d[m]} + 9'(m * CELL_STRIDE);
			end
		end

		// Refresh pack values only on summary-family frames
		low_volt_d  = low_volt_q;
		low_cell_d  = low_cell_q;
		high_volt_d = high_volt_q;
		high_cell_d = high_cell_q;
		if (family_hit) begin
			low_volt_d  = scan_lo;
			low_cell_d  = scan_lo_cell;
			high_volt_d = scan_hi;
			high_cell_d = scan_hi_cell;
		end

		// Mark seen frame types and request stale clears
		seen_d  = seen_q;
		stale_d = '0;
		for (int m = 0; m < MODULES; m++) begin
			if (type_ok && frame_mod == 8'(m + 1)) begin
				stale_d[m] = 1'b1;
				for (int t = 0; t < FRAME_TYPES; t++) begin
					if (frame_type == 8'(t + 1)) begin
						seen_d[m * FRAME_TYPES + t] = 1'b1;
					end
				end
			end
		end

		// Raise the ghost flag for addresses past the last module
		ghost_d = ghost_q || (type_ok && frame_mod > 8'(MODULES));
	end

	// Advance the request into the state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int m = 0; m < MODULES; m++) begin
				min_volt_q[m] <= '0;
				min_cell_q[m] <= '0;
				max_volt_q[m] <= '0;
				max_cell_q[m] <= '0;
			end
			seen_q        <= '0;
			ghost_q       <= 1'b0;
			pump_state_q  <= '0;
			pump_speed_q  <= '0;
			pump_faults_q <= '0;
			low_volt_q    <= '0;
			low_cell_q    <= '0;
			high_volt_q   <= '0;
			high_cell_q   <= '0;
			stale_q       <= '0;
			updated_q     <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				min_volt_q  <= min_volt_d;
				min_cell_q  <= min_cell_d;
				max_volt_q  <= max_volt_d;
				max_cell_q  <= max_cell_d;
				seen_q      <= seen_d;
				ghost_q     <= ghost_d;
				low_volt_q  <= low_volt_d;
				low_cell_q  <= low_cell_d;
				high_volt_q <= high_volt_d;
				high_cell_q <= high_cell_d;
				stale_q     <= stale_d;
				updated_q   <= updated_d;
				// Decode the pump status frame
				if (id_s1 == pump_id_q) begin
					pump_state_q  <= data_s1[0][5:2];
					pump_speed_q  <= {data_s1[2], data_s1[1]};
					pump_faults_q <= data_s1[7][3:0];
				end
			end
		end
	end

	// Drive the result ports
	assign cov_ext   = {{COV_W{1'b0}}, seen_q};
	assign stale_ext = {{STALE_W{1'b0}}, stale_q};

	assign out_valid       = out_valid_q;
	assign lowest_volt     = low_volt_q;
	assign lowest_cell     = low_cell_q;
	assign highest_volt    = high_volt_q;
	assign highest_cell    = high_cell_q;
	assign coverage_bits   = cov_ext[COV_W-1:0];
	assign stale_clear     = stale_ext[STALE_W-1:0];
	assign ghost_flag      = ghost_q;
	assign updated_module  = updated_q;
	assign pump_state      = pump_state_q;
	assign pump_speed      = pump_speed_q;
	assign pump_fault_bits = pump_faults_q;

endmodule
